// ===== design/readback_slot_table_first_fit_macros.svh =====
// assertion macros for the readback slot table
`ifndef READBACK_SLOT_TABLE_FIRST_FIT_MACROS_SVH
`define READBACK_SLOT_TABLE_FIRST_FIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define RSTFF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RSTFF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rstff_pkg.sv =====
// shared types and codes of the readback slot table
package rstff_pkg;

    localparam int VAL_W     = 32;
    localparam int CNT_W     = 5;
    localparam int TOTAL_W   = 64;
    localparam int CFG_IDX_W = 2;
    localparam int MAXP_W    = 5;

    typedef enum logic [1:0] {
        REQ_NEW    = 2'd0,
        REQ_CANCEL = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_FLUSH  = 2'd3
    } req_type_t;

    localparam logic [1:0] KIND_ACCEPT  = 2'd0;
    localparam logic [1:0] KIND_REJECT  = 2'd1;
    localparam logic [1:0] KIND_DELIVER = 2'd2;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_FULL     = 2'd1;
    localparam logic [1:0] ERR_NO_SPACE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_STAGING     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PENDING = 2'd1;

    localparam logic [VAL_W-1:0]  STAGING_RESET = 32'd67108864;
    localparam logic [MAXP_W-1:0] MAXP_RESET    = 5'd16;

    typedef struct packed {
        logic [VAL_W-1:0] id;
        logic [VAL_W-1:0] offset;
        logic [VAL_W-1:0] size;
        logic [VAL_W-1:0] due;
    } slot_t;

    typedef enum logic [1:0] {
        SA_HOLD,
        SA_LOAD,
        SA_FROM_NEXT
    } slot_act_t;

    typedef struct packed {
        logic id_hit;
        logic due;
    } slot_flags_t;

    typedef enum logic [2:0] {
        FA_HOLD,
        FA_LOAD,
        FA_FROM_NEXT,
        FA_FROM_PREV,
        FA_ADD_LEN,
        FA_GROW_DOWN,
        FA_CUT,
        FA_ABSORB
    } free_act_t;

    typedef struct packed {
        logic le;
        logic fit;
        logic exact;
        logic end_touch;
        logic begin_touch;
    } free_flags_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [VAL_W-1:0] id;
        logic [VAL_W-1:0] offset;
        logic [VAL_W-1:0] size;
        logic [1:0]       err;
    } result_t;

endpackage

// ===== design/rstff_slot_cell.sv =====
// one pending-request cell of the slot chain
module rstff_slot_cell
    import rstff_pkg::*;
(
    input  logic             clk,
    input  slot_act_t        act,
    input  slot_t            load_data,
    input  slot_t            next_data,
    input  logic [VAL_W-1:0] match_id,
    input  logic [VAL_W-1:0] frame,
    output slot_t            data,
    output slot_flags_t      flags
);

    slot_t data_reg;

    always_ff @(posedge clk)
    begin
        case (act)
            SA_LOAD:      data_reg <= load_data;
            SA_FROM_NEXT: data_reg <= next_data;
            default:      data_reg <= data_reg;
        endcase
    end

    assign data         = data_reg;
    assign flags.id_hit = (data_reg.id == match_id);
    assign flags.due    = (frame >= data_reg.due);

endmodule

// ===== design/rstff_free_cell.sv =====
// one free-region cell of the sorted free chain
module rstff_free_cell
    import rstff_pkg::*;
#(
    parameter int            RW      = 32,
    parameter logic [RW-1:0] RST_LEN = '0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  free_act_t        act,
    input  logic [RW-1:0]    ins_start,
    input  logic [RW-1:0]    ins_len,
    input  logic [VAL_W-1:0] req_size,
    input  logic [RW-1:0]    prev_start,
    input  logic [RW-1:0]    prev_len,
    input  logic [RW-1:0]    next_start,
    input  logic [RW-1:0]    next_len,
    output logic [RW-1:0]    start,
    output logic [RW-1:0]    len,
    output free_flags_t      flags
);

    localparam int SW = RW + 1;

    logic [RW-1:0] start_reg;
    logic [RW-1:0] len_reg;
    logic [RW-1:0] cut;
    logic [SW-1:0] end_sum;
    logic [SW-1:0] ins_end;

    // request never exceeds the region it is cut from
    assign cut     = req_size[RW-1:0];
    assign end_sum = SW'(start_reg) + SW'(len_reg);
    assign ins_end = SW'(ins_start) + SW'(ins_len);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            len_reg   <= RST_LEN;
        end
        else
        begin
            case (act)
                FA_LOAD:
                begin
                    start_reg <= ins_start;
                    len_reg   <= ins_len;
                end
                FA_FROM_NEXT:
                begin
                    start_reg <= next_start;
                    len_reg   <= next_len;
                end
                FA_FROM_PREV:
                begin
                    start_reg <= prev_start;
                    len_reg   <= prev_len;
                end
                FA_ADD_LEN:   len_reg <= len_reg + ins_len;
                FA_GROW_DOWN:
                begin
                    start_reg <= ins_start;
                    len_reg   <= len_reg + ins_len;
                end
                FA_CUT:
                begin
                    start_reg <= start_reg + cut;
                    len_reg   <= len_reg - cut;
                end
                FA_ABSORB:    len_reg <= len_reg + ins_len + next_len;
                default:
                begin
                    start_reg <= start_reg;
                    len_reg   <= len_reg;
                end
            endcase
        end
    end

    assign start             = start_reg;
    assign len               = len_reg;
    assign flags.le          = (start_reg <= ins_start);
    assign flags.fit         = (33'(len_reg) >= 33'(req_size));
    assign flags.exact       = (33'(len_reg) == 33'(req_size));
    assign flags.end_touch   = (end_sum == SW'(ins_start));
    assign flags.begin_touch = (ins_end == SW'(start_reg));

endmodule

// ===== design/readback_slot_table_first_fit.sv =====
// top level of the readback slot table with first-fit staging allocator
//
// Command-style block: an item is taken when start is high and busy is low,
// and its results come out afterwards on strobe, one per cycle, with no way
// for the receiver to hold them off. All results of one item carry the
// counters as they stand after that whole item. A new request goes through a
// capacity check, then, if there is room, a first-fit search over the free
// chain, and gives one result beat. A cancel finds its slot, frees its region
// if it finds one and gives no result. A tick or flush walks the slot chain
// one slot a cycle, except that each delivery halts the walk to merge its
// region back into the free chain; the beats of all deliveries go out after
// the walk.
// Configuration writes are taken only while busy is low; writing the staging
// size rebuilds the free chain in the same cycle. No clearing pass follows
// reset.
`include "readback_slot_table_first_fit_macros.svh"

module readback_slot_table_first_fit
    import rstff_pkg::*;
#(
    parameter int MAX_SLOTS        = 16,
    parameter int MAX_FREE_REGIONS = 17,
    parameter int ADDR_BITS        = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // command channel
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           req_type,
    input  logic [VAL_W-1:0]     req_size,
    input  logic [VAL_W-1:0]     frame_issued,
    input  logic [VAL_W-1:0]     frames_to_wait,
    input  logic [VAL_W-1:0]     request_id,
    input  logic [VAL_W-1:0]     current_frame,
    // configuration channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_data,
    // result channel
    output logic                 strobe,
    output logic [1:0]           result_kind,
    output logic [VAL_W-1:0]     result_id,
    output logic [VAL_W-1:0]     staging_offset,
    output logic [VAL_W-1:0]     data_size,
    output logic [1:0]           error_code,
    output logic                 last,
    output logic [CNT_W-1:0]     pending_count,
    output logic [VAL_W-1:0]     completed_count,
    output logic [VAL_W-1:0]     failed_count,
    output logic [TOTAL_W-1:0]   bytes_delivered,
    output logic [VAL_W-1:0]     staging_in_use
);

    // region words only need the address width, capped at the 32-bit fields
    localparam int RW   = (ADDR_BITS < 32) ? ADDR_BITS : 32;
    localparam int SCW  = $clog2(MAX_SLOTS + 1);
    localparam int FCW  = $clog2(MAX_FREE_REGIONS + 1);
    localparam int IW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int MAXF = MAX_FREE_REGIONS;

    localparam logic [RW-1:0]  RST_LEN  = RW'(STAGING_RESET);
    localparam logic [FCW-1:0] RST_FCNT = (RST_LEN != '0) ? FCW'(1) : '0;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_ALLOC   = 6'b000010,
        S_FIND    = 6'b000100,
        S_SCAN    = 6'b001000,
        S_RELEASE = 6'b010000,
        S_EMIT    = 6'b100000
    } state_t;

    // control state
    state_t              state_reg, state_next;
    logic [MAXP_W-1:0]   maxp_reg;
    logic [SCW-1:0]      scount_reg, scount_next;
    logic [FCW-1:0]      fcount_reg, fcount_next;
    logic [VAL_W-1:0]    next_id_reg, next_id_next;
    logic [VAL_W-1:0]    done_reg, done_next;
    logic [VAL_W-1:0]    fail_reg, fail_next;
    logic [TOTAL_W-1:0]  bytes_reg, bytes_next;
    logic [VAL_W-1:0]    used_reg, used_next;
    logic [SCW-1:0]      idx_reg, idx_next;
    logic [SCW-1:0]      nres_reg, nres_next;
    logic [SCW-1:0]      rd_reg, rd_next;
    logic                strobe_reg, strobe_next;
    logic                last_reg, last_next;

    // latched command payload
    req_type_t           op_reg;
    logic [VAL_W-1:0]    size_reg;
    logic [VAL_W-1:0]    due_reg;
    logic [VAL_W-1:0]    rid_reg;
    logic [VAL_W-1:0]    frame_reg;
    logic [VAL_W-1:0]    rel_off_reg, rel_off_next;
    logic [VAL_W-1:0]    rel_size_reg, rel_size_next;

    // result buffer, filled during the step and drained afterwards
    result_t             res_mem [MAX_SLOTS];
    result_t             res_q_reg;
    logic                res_we;
    result_t             res_wd;

    // slot chain
    slot_t               slot_q   [MAX_SLOTS];
    slot_t               slot_nbr [MAX_SLOTS];
    slot_flags_t         sflags   [MAX_SLOTS];
    slot_act_t           sact     [MAX_SLOTS];
    slot_t               new_slot;
    logic [MAX_SLOTS-1:0] svalid, shit, sfirst, shit_incl, ssel, sabove;
    logic                shany;
    slot_t               hit_data, scan_data;
    logic                scan_due;

    // free chain
    logic [RW-1:0]       fq_start [MAXF];
    logic [RW-1:0]       fq_len   [MAXF];
    logic [RW-1:0]       fp_start [MAXF];
    logic [RW-1:0]       fp_len   [MAXF];
    logic [RW-1:0]       fn_start [MAXF];
    logic [RW-1:0]       fn_len   [MAXF];
    free_flags_t         fflags   [MAXF];
    free_act_t           fact     [MAXF];
    logic [RW-1:0]       ins_start, ins_len;
    logic [MAXF-1:0]     fvalid, lep, fabove, is_prev, is_pos, is_next;
    logic [MAXF-1:0]     ffit, ffirst, fincl;
    logic                fany, fexact, merge_prev, merge_next;
    logic [RW-1:0]       alloc_off;

    logic [7:0]          cap;
    logic                table_full;
    logic                accept;
    logic [IW-1:0]       wr_addr;

    assign accept  = start && (state_reg == S_IDLE);
    assign wr_addr = nres_reg[IW-1:0];

    assign cap = ({3'b000, maxp_reg} > 8'(MAX_SLOTS)) ? 8'(MAX_SLOTS)
                                                      : {3'b000, maxp_reg};
    assign table_full = (8'(scount_reg) >= cap);

    assign new_slot = '{id: next_id_reg, offset: VAL_W'(alloc_off),
                        size: size_reg, due: due_reg};

    // slot cells, each shifting down from its upper neighbor on removal
    for (genvar g = 0; g < MAX_SLOTS; g++)
    begin : g_slot
        if (g == MAX_SLOTS - 1)
        begin : g_top
            assign slot_nbr[g] = slot_q[g];
        end
        else
        begin : g_mid
            assign slot_nbr[g] = slot_q[g+1];
        end

        rstff_slot_cell u_cell (
            .clk       (clk),
            .act       (sact[g]),
            .load_data (new_slot),
            .next_data (slot_nbr[g]),
            .match_id  (rid_reg),
            .frame     (frame_reg),
            .data      (slot_q[g]),
            .flags     (sflags[g])
        );
    end

    // free cells, sorted by start, shifting either way
    for (genvar g = 0; g < MAXF; g++)
    begin : g_free
        if (g == 0)
        begin : g_low
            assign fp_start[g] = fq_start[g];
            assign fp_len[g]   = fq_len[g];
        end
        else
        begin : g_lowmid
            assign fp_start[g] = fq_start[g-1];
            assign fp_len[g]   = fq_len[g-1];
        end
        if (g == MAXF - 1)
        begin : g_high
            assign fn_start[g] = fq_start[g];
            assign fn_len[g]   = fq_len[g];
        end
        else
        begin : g_highmid
            assign fn_start[g] = fq_start[g+1];
            assign fn_len[g]   = fq_len[g+1];
        end

        rstff_free_cell #(
            .RW      (RW),
            .RST_LEN ((g == 0) ? RST_LEN : '0)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .act        (fact[g]),
            .ins_start  (ins_start),
            .ins_len    (ins_len),
            .req_size   (size_reg),
            .prev_start (fp_start[g]),
            .prev_len   (fp_len[g]),
            .next_start (fn_start[g]),
            .next_len   (fn_len[g]),
            .start      (fq_start[g]),
            .len        (fq_len[g]),
            .flags      (fflags[g])
        );
    end

    // slot chain decode: first id match, scan select
    always_comb
    begin
        shany     = 1'b0;
        hit_data  = '0;
        scan_data = '0;
        scan_due  = 1'b0;
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            svalid[i]    = (SCW'(i) < scount_reg);
            shit[i]      = svalid[i] && sflags[i].id_hit;
            sfirst[i]    = shit[i] && !shany;
            shany        = shany || shit[i];
            shit_incl[i] = shany;
            ssel[i]      = (SCW'(i) == idx_reg);
            sabove[i]    = (SCW'(i) >= idx_reg);
            hit_data     = hit_data | (sfirst[i] ? slot_q[i] : '0);
            scan_data    = scan_data | (ssel[i] ? slot_q[i] : '0);
            scan_due     = scan_due | (ssel[i] & sflags[i].due);
        end
    end

    // free chain decode: insert position, neighbors, first fit
    // the insert position is the first region starting above the freed one,
    // even when a resize has left the chain out of order
    always_comb
    begin
        fany       = 1'b0;
        fexact     = 1'b0;
        alloc_off  = '0;
        merge_prev = 1'b0;
        merge_next = 1'b0;
        for (int i = 0; i < MAXF; i++)
        begin
            fvalid[i] = (FCW'(i) < fcount_reg);
            lep[i]    = fvalid[i] && fflags[i].le;
        end
        fabove[0] = !lep[0];
        is_pos[0] = !lep[0];
        for (int i = 1; i < MAXF; i++)
        begin
            fabove[i] = fabove[i-1] || !lep[i];
            is_pos[i] = fabove[i] && !fabove[i-1];
        end
        for (int i = 0; i < MAXF - 1; i++)
        begin
            is_prev[i] = !fabove[i] && fabove[i+1];
        end
        is_prev[MAXF-1] = !fabove[MAXF-1];
        for (int i = 0; i < MAXF; i++)
        begin
            is_next[i] = is_pos[i] && fvalid[i];
            merge_prev = merge_prev | (is_prev[i] & fflags[i].end_touch);
            merge_next = merge_next | (is_next[i] & fflags[i].begin_touch);
            ffit[i]    = fvalid[i] && fflags[i].fit;
            ffirst[i]  = ffit[i] && !fany;
            fany       = fany || ffit[i];
            fincl[i]   = fany;
            fexact     = fexact | (ffirst[i] & fflags[i].exact);
            alloc_off  = alloc_off | (ffirst[i] ? fq_start[i] : '0);
        end
    end

    // step sequencer
    always_comb
    begin
        state_next    = state_reg;
        scount_next   = scount_reg;
        fcount_next   = fcount_reg;
        next_id_next  = next_id_reg;
        done_next     = done_reg;
        fail_next     = fail_reg;
        bytes_next    = bytes_reg;
        used_next     = used_reg;
        idx_next      = idx_reg;
        nres_next     = nres_reg;
        rd_next       = rd_reg;
        rel_off_next  = rel_off_reg;
        rel_size_next = rel_size_reg;
        strobe_next   = 1'b0;
        last_next     = 1'b0;
        res_we        = 1'b0;
        res_wd        = '0;
        ins_start     = '0;
        ins_len       = '0;
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            sact[i] = SA_HOLD;
        end
        for (int i = 0; i < MAXF; i++)
        begin
            fact[i] = FA_HOLD;
        end

        case (state_reg)
            S_IDLE:
            begin
                // staging resize rebuilds the free chain as one region, or empty for size zero
                if (cfg_valid && (cfg_index == CFG_STAGING))
                begin
                    ins_len     = cfg_data[RW-1:0];
                    fact[0]     = FA_LOAD;
                    fcount_next = (ins_len != '0) ? FCW'(1) : '0;
                end
                if (start)
                begin
                    idx_next = '0;
                    case (req_type_t'(req_type))
                        REQ_NEW:
                        begin
                            if (table_full)
                            begin
                                res_we     = 1'b1;
                                res_wd     = '{kind: KIND_REJECT, id: '0, offset: '0,
                                               size: req_size, err: ERR_FULL};
                                fail_next  = fail_reg + 1'b1;
                                nres_next  = SCW'(1);
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_ALLOC;
                            end
                        end
                        REQ_CANCEL: state_next = S_FIND;
                        default:    state_next = S_SCAN;
                    endcase
                end
            end

            S_ALLOC:
            begin
                if (fany)
                begin
                    for (int i = 0; i < MAXF; i++)
                    begin
                        if (fexact && fincl[i])
                        begin
                            fact[i] = FA_FROM_NEXT;
                        end
                        else if (ffirst[i])
                        begin
                            fact[i] = FA_CUT;
                        end
                    end
                    if (fexact)
                    begin
                        fcount_next = fcount_reg - 1'b1;
                    end
                    for (int i = 0; i < MAX_SLOTS; i++)
                    begin
                        if (SCW'(i) == scount_reg)
                        begin
                            sact[i] = SA_LOAD;
                        end
                    end
                    scount_next  = scount_reg + 1'b1;
                    used_next    = used_reg + size_reg;
                    res_wd       = '{kind: KIND_ACCEPT, id: next_id_reg,
                                     offset: VAL_W'(alloc_off), size: size_reg,
                                     err: ERR_NONE};
                    next_id_next = next_id_reg + 1'b1;
                end
                else
                begin
                    res_wd    = '{kind: KIND_REJECT, id: '0, offset: '0,
                                  size: size_reg, err: ERR_NO_SPACE};
                    fail_next = fail_reg + 1'b1;
                end
                res_we     = 1'b1;
                nres_next  = SCW'(1);
                state_next = S_EMIT;
            end

            S_FIND:
            begin
                if (shany)
                begin
                    for (int i = 0; i < MAX_SLOTS; i++)
                    begin
                        if (shit_incl[i])
                        begin
                            sact[i] = SA_FROM_NEXT;
                        end
                    end
                    scount_next   = scount_reg - 1'b1;
                    rel_off_next  = hit_data.offset;
                    rel_size_next = hit_data.size;
                    used_next     = used_reg - hit_data.size;
                    state_next    = S_RELEASE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_SCAN:
            begin
                if (idx_reg >= scount_reg)
                begin
                    state_next = (nres_reg == '0) ? S_IDLE : S_EMIT;
                end
                else if ((op_reg == REQ_FLUSH) || scan_due)
                begin
                    res_we = 1'b1;
                    res_wd = '{kind: KIND_DELIVER, id: scan_data.id,
                               offset: scan_data.offset, size: scan_data.size,
                               err: ERR_NONE};
                    nres_next = nres_reg + 1'b1;
                    done_next = done_reg + 1'b1;
                    bytes_next = bytes_reg + TOTAL_W'(scan_data.size);
                    used_next = used_reg - scan_data.size;
                    for (int i = 0; i < MAX_SLOTS; i++)
                    begin
                        if (sabove[i])
                        begin
                            sact[i] = SA_FROM_NEXT;
                        end
                    end
                    scount_next   = scount_reg - 1'b1;
                    rel_off_next  = scan_data.offset;
                    rel_size_next = scan_data.size;
                    state_next    = S_RELEASE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_RELEASE:
            begin
                // coalesce the freed region with neighbors, else insert it if there is room
                ins_start = rel_off_reg[RW-1:0];
                ins_len   = rel_size_reg[RW-1:0];
                if (rel_size_reg != '0)
                begin
                    if (merge_prev && merge_next)
                    begin
                        for (int i = 0; i < MAXF; i++)
                        begin
                            if (is_prev[i])
                            begin
                                fact[i] = FA_ABSORB;
                            end
                            else if (fabove[i])
                            begin
                                fact[i] = FA_FROM_NEXT;
                            end
                        end
                        fcount_next = fcount_reg - 1'b1;
                    end
                    else if (merge_prev)
                    begin
                        for (int i = 0; i < MAXF; i++)
                        begin
                            if (is_prev[i])
                            begin
                                fact[i] = FA_ADD_LEN;
                            end
                        end
                    end
                    else if (merge_next)
                    begin
                        for (int i = 0; i < MAXF; i++)
                        begin
                            if (is_next[i])
                            begin
                                fact[i] = FA_GROW_DOWN;
                            end
                        end
                    end
                    else if (fcount_reg < FCW'(MAXF))
                    begin
                        // open a hole at the insert position
                        for (int i = 0; i < MAXF; i++)
                        begin
                            if (is_pos[i])
                            begin
                                fact[i] = FA_LOAD;
                            end
                            else if (fabove[i])
                            begin
                                fact[i] = FA_FROM_PREV;
                            end
                        end
                        fcount_next = fcount_reg + 1'b1;
                    end
                end
                state_next = (op_reg == REQ_CANCEL) ? S_IDLE : S_SCAN;
            end

            S_EMIT:
            begin
                strobe_next = 1'b1;
                rd_next     = rd_reg + 1'b1;
                if ((rd_reg + 1'b1) == nres_reg)
                begin
                    last_next  = 1'b1;
                    rd_next    = '0;
                    nres_next  = '0;
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            maxp_reg    <= MAXP_RESET;
            scount_reg  <= '0;
            fcount_reg  <= RST_FCNT;
            next_id_reg <= VAL_W'(1);
            done_reg    <= '0;
            fail_reg    <= '0;
            bytes_reg   <= '0;
            used_reg    <= '0;
            idx_reg     <= '0;
            nres_reg    <= '0;
            rd_reg      <= '0;
            strobe_reg  <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            if ((state_reg == S_IDLE) && cfg_valid && (cfg_index == CFG_MAX_PENDING))
            begin
                maxp_reg <= cfg_data[MAXP_W-1:0];
            end
            scount_reg  <= scount_next;
            fcount_reg  <= fcount_next;
            next_id_reg <= next_id_next;
            done_reg    <= done_next;
            fail_reg    <= fail_next;
            bytes_reg   <= bytes_next;
            used_reg    <= used_next;
            idx_reg     <= idx_next;
            nres_reg    <= nres_next;
            rd_reg      <= rd_next;
            strobe_reg  <= strobe_next;
            last_reg    <= last_next;
        end
    end

    // command payload, captured on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= req_type_t'(req_type);
            size_reg  <= req_size;
            due_reg   <= frame_issued + frames_to_wait;
            rid_reg   <= request_id;
            frame_reg <= current_frame;
        end
        rel_off_reg  <= rel_off_next;
        rel_size_reg <= rel_size_next;
    end

    // result buffer, registered read straight into the output beat
    always_ff @(posedge clk)
    begin
        if (res_we)
        begin
            res_mem[wr_addr] <= res_wd;
        end
        if (state_reg == S_EMIT)
        begin
            res_q_reg <= res_mem[rd_reg[IW-1:0]];
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    assign strobe          = strobe_reg;
    assign last            = last_reg;
    assign result_kind     = res_q_reg.kind;
    assign result_id       = res_q_reg.id;
    assign staging_offset  = res_q_reg.offset;
    assign data_size       = res_q_reg.size;
    assign error_code      = res_q_reg.err;
    // counters hold still while the beats of a step go out
    assign pending_count   = CNT_W'(scount_reg);
    assign completed_count = done_reg;
    assign failed_count    = fail_reg;
    assign bytes_delivered = bytes_reg;
    assign staging_in_use  = used_reg;

    // every accepted command is out of idle in the cycle after it is taken
    `RSTFF_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, accept, state_reg != S_IDLE, "accepted command stayed idle")
    // each drain cycle yields a beat on the next cycle
    `RSTFF_ASSERT_NEXT(a_emit_gives_beat, clk, rst_n, state_reg == S_EMIT, strobe_reg, "drain cycle gave no beat")
    // the final beat of a step is out only once draining has ended
    `RSTFF_ASSERT_NOW(a_last_ends_drain, clk, rst_n, strobe_reg && last_reg, state_reg == S_IDLE, "last beat while still draining")
    // occupancy of both chains stays within their cells
    `RSTFF_ASSERT_NOW(a_chain_bounds, clk, rst_n, 1'b1, (scount_reg <= SCW'(MAX_SLOTS)) && (fcount_reg <= FCW'(MAXF)), "chain occupancy out of range")

endmodule
